FILE: rtl/core/tbb_pkg.sv
// ----------------------------------------------------------------------------
// tbb_pkg
// Shared types, constants and helpers of the transformed bounding-box engine.
// ----------------------------------------------------------------------------
package tbb_pkg;

    localparam int COORD_W    = 32;   // Q16.16 coordinate
    localparam int COEF_W     = 16;   // Q4.12 coefficient
    localparam int ABS_W      = COEF_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3 * COEF_W;
    localparam int OP_W       = COORD_W + 1;       // a+b, b-a, 2a
    localparam int PC_W       = COEF_W + OP_W;     // signed coef times operand
    localparam int PE_W       = ABS_W + 1 + OP_W;  // magnitude times operand
    localparam int SUM_W      = 52;                // units of 2^-29
    localparam int RND_W      = SUM_W + 1;
    localparam int FRAC_SHIFT = 13;
    localparam int Q_W        = RND_W - FRAC_SHIFT;

    typedef logic [COORD_W-1:0]    coord_t;
    typedef coord_t [2:0]          vec3_t;
    typedef logic [CFG_DATA_W-1:0] row_t;

    typedef enum logic [1:0] {
        ACT_VERTEX    = 2'd0,
        ACT_LOCAL_BOX = 2'd1,
        ACT_XFORM_BOX = 2'd2
    } action_t;

    localparam logic [CFG_IDX_W-1:0] CFG_LIN_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Z  = 3'd5;

    localparam row_t LIN_ROW0_RST = 48'h0010_0000_0000;
    localparam row_t LIN_ROW1_RST = 48'h0000_0010_0000;
    localparam row_t LIN_ROW2_RST = 48'h0000_0000_0010;

    localparam coord_t COORD_MAX = 32'h7FFF_FFFF;
    localparam coord_t COORD_MIN = 32'h8000_0000;

    localparam logic [RND_W-1:0] RND_HALF = 53'd4096;

    // Per-item control that rides along the pipeline
    typedef struct packed {
        logic fold;   // fold into running bound (vertex or local box)
        logic raw;    // local box: bypass the transform
        logic last;   // closes the run
    } tbb_ctl_t;

    typedef struct packed {
        row_t [2:0] lin;
        vec3_t      shift;
    } tbb_xf_cfg_t;

    // Truncate a 2^-29 value to Q16.16 (the caller adds the half) and saturate
    function automatic coord_t round_sat(input logic [RND_W-1:0] v);
        logic [Q_W-1:0] q;
        logic [Q_W-COORD_W:0] top;
        begin
            q   = v[RND_W-1:FRAC_SHIFT];
            top = q[Q_W-1:COORD_W-1];
            if ((&top) || !(|top))
            begin
                round_sat = q[COORD_W-1:0];
            end
            else if (q[Q_W-1])
            begin
                round_sat = COORD_MIN;
            end
            else
            begin
                round_sat = COORD_MAX;
            end
        end
    endfunction

endpackage

FILE: rtl/core/tbb_cfg.sv
// ----------------------------------------------------------------------------
// tbb_cfg
// Configuration register file: linear part rows and translation.
// ----------------------------------------------------------------------------
module tbb_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tbb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbb_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tbb_pkg::tbb_xf_cfg_t               xf_cfg
);

    tbb_pkg::tbb_xf_cfg_t cfg_reg;
    tbb_pkg::tbb_xf_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign xf_cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                tbb_pkg::CFG_LIN_ROW0: cfg_next.lin[0]   = cfg_data;
                tbb_pkg::CFG_LIN_ROW1: cfg_next.lin[1]   = cfg_data;
                tbb_pkg::CFG_LIN_ROW2: cfg_next.lin[2]   = cfg_data;
                tbb_pkg::CFG_SHIFT_X:  cfg_next.shift[0] = cfg_data[tbb_pkg::COORD_W-1:0];
                tbb_pkg::CFG_SHIFT_Y:  cfg_next.shift[1] = cfg_data[tbb_pkg::COORD_W-1:0];
                tbb_pkg::CFG_SHIFT_Z:  cfg_next.shift[2] = cfg_data[tbb_pkg::COORD_W-1:0];
                default:               cfg_next = cfg_reg;   // drop unmapped writes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lin[0] <= tbb_pkg::LIN_ROW0_RST;
            cfg_reg.lin[1] <= tbb_pkg::LIN_ROW1_RST;
            cfg_reg.lin[2] <= tbb_pkg::LIN_ROW2_RST;
            cfg_reg.shift  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/tbb_xform.sv
// ----------------------------------------------------------------------------
// tbb_xform
// Transform pipeline: input register, operand forming, products, sums,
// rounding and saturation. One candidate box per item of actions 0 to 2.
// ----------------------------------------------------------------------------
module tbb_xform (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tbb_pkg::tbb_xf_cfg_t     xf_cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               action,
    input  tbb_pkg::vec3_t           a,
    input  tbb_pkg::vec3_t           b,
    input  logic                     is_last,
    output logic                     out_valid,
    input  logic                     out_ready,
    output tbb_pkg::tbb_ctl_t        out_ctl,
    output tbb_pkg::vec3_t           out_lo,
    output tbb_pkg::vec3_t           out_hi
);

    localparam int CW  = tbb_pkg::COORD_W;
    localparam int OW  = tbb_pkg::OP_W;
    localparam int PCW = tbb_pkg::PC_W;
    localparam int PEW = tbb_pkg::PE_W;
    localparam int SW  = tbb_pkg::SUM_W;
    localparam int RW  = tbb_pkg::RND_W;
    localparam int KW  = tbb_pkg::COEF_W;
    localparam int FS  = tbb_pkg::FRAC_SHIFT;

    // stage enables, back to front
    logic en0, en1, en2, en3, en4;

    // stage 0: input register
    logic              v0_reg;
    logic [1:0]        act0_reg;
    tbb_pkg::tbb_ctl_t ctl0_reg, ctl0_next;
    tbb_pkg::vec3_t    a0_reg, b0_reg;
    logic              act_ok;

    // stage 1: operands
    logic                  v1_reg;
    tbb_pkg::tbb_ctl_t     ctl1_reg;
    logic [2:0][OW-1:0]    opc1_reg, opc1_next;
    logic [2:0][OW-1:0]    ope1_reg, ope1_next;

    // stage 2: products
    logic                    v2_reg;
    tbb_pkg::tbb_ctl_t       ctl2_reg;
    logic [2:0][2:0][PCW-1:0] pc2_reg, pc2_next;
    logic [2:0][2:0][PEW-1:0] pe2_reg, pe2_next;
    tbb_pkg::vec3_t          rlo2_reg, rhi2_reg;

    // stage 3: sums
    logic               v3_reg;
    tbb_pkg::tbb_ctl_t  ctl3_reg;
    logic [2:0][SW-1:0] c3_reg, c3_next;
    logic [2:0][SW-1:0] e3_reg, e3_next;
    tbb_pkg::vec3_t     rlo3_reg, rhi3_reg;

    // stage 4: candidate box
    logic              v4_reg;
    tbb_pkg::tbb_ctl_t ctl4_reg;
    tbb_pkg::vec3_t    lo4_reg, lo4_next;
    tbb_pkg::vec3_t    hi4_reg, hi4_next;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign in_ready = en0;

    assign act_ok = (action == tbb_pkg::ACT_VERTEX) || (action == tbb_pkg::ACT_LOCAL_BOX)
                    || (action == tbb_pkg::ACT_XFORM_BOX);

    always_comb
    begin
        ctl0_next.fold = (action != tbb_pkg::ACT_XFORM_BOX);
        ctl0_next.raw  = (action == tbb_pkg::ACT_LOCAL_BOX);
        ctl0_next.last = is_last;
    end

    // operands: vertex uses 2a so that both transforms share the 2^-29 scale
    always_comb
    begin
        logic [OW-1:0] ae;
        logic [OW-1:0] be;
        for (int j = 0; j < 3; j++)
        begin
            ae = {a0_reg[j][CW-1], a0_reg[j]};
            be = {b0_reg[j][CW-1], b0_reg[j]};
            case (act0_reg)
                tbb_pkg::ACT_VERTEX:
                begin
                    opc1_next[j] = {a0_reg[j], 1'b0};
                    ope1_next[j] = '0;
                end
                tbb_pkg::ACT_LOCAL_BOX:
                begin
                    opc1_next[j] = ae;
                    ope1_next[j] = be;
                end
                tbb_pkg::ACT_XFORM_BOX:
                begin
                    opc1_next[j] = ae + be;
                    ope1_next[j] = be - ae;
                end
                default:
                begin
                    opc1_next[j] = ae;
                    ope1_next[j] = '0;
                end
            endcase
        end
    end

    // products: signed coefficient for the center, magnitude for the extent
    always_comb
    begin
        logic signed [KW-1:0]  cf;
        logic [KW:0]           cext;
        logic signed [KW+1:0]  am;
        logic signed [OW-1:0]  opc_s;
        logic signed [OW-1:0]  ope_s;
        logic signed [PCW-1:0] prod_c;
        logic signed [PEW-1:0] prod_e;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cf     = $signed(xf_cfg.lin[i][(2-j)*KW +: KW]);
                cext   = {cf[KW-1], cf};
                am     = $signed({1'b0, (cf[KW-1] ? ((KW+1)'(0) - cext) : cext)});
                opc_s  = $signed(opc1_reg[j]);
                ope_s  = $signed(ope1_reg[j]);
                prod_c = PCW'(cf) * PCW'(opc_s);
                prod_e = PEW'(am) * PEW'(ope_s);
                pc2_next[i][j] = prod_c;
                pe2_next[i][j] = prod_e;
            end
        end
    end

    always_comb
    begin
        logic [CW-1:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            sh = xf_cfg.shift[i];
            c3_next[i] = {{(SW-PCW){pc2_reg[i][0][PCW-1]}}, pc2_reg[i][0]}
                       + {{(SW-PCW){pc2_reg[i][1][PCW-1]}}, pc2_reg[i][1]}
                       + {{(SW-PCW){pc2_reg[i][2][PCW-1]}}, pc2_reg[i][2]}
                       + {{(SW-CW-FS){sh[CW-1]}}, sh, {FS{1'b0}}};
            e3_next[i] = {{(SW-PEW){pe2_reg[i][0][PEW-1]}}, pe2_reg[i][0]}
                       + {{(SW-PEW){pe2_reg[i][1][PEW-1]}}, pe2_reg[i][1]}
                       + {{(SW-PEW){pe2_reg[i][2][PEW-1]}}, pe2_reg[i][2]};
        end
    end

    always_comb
    begin
        logic [RW-1:0] cw;
        logic [RW-1:0] ew;
        for (int i = 0; i < 3; i++)
        begin
            cw = {c3_reg[i][SW-1], c3_reg[i]};
            ew = {e3_reg[i][SW-1], e3_reg[i]};
            if (ctl3_reg.raw)
            begin
                lo4_next[i] = rlo3_reg[i];
                hi4_next[i] = rhi3_reg[i];
            end
            else
            begin
                lo4_next[i] = tbb_pkg::round_sat(cw - ew + tbb_pkg::RND_HALF);
                hi4_next[i] = tbb_pkg::round_sat(cw + ew + tbb_pkg::RND_HALF);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            // drop the unused action code at the door
            if (en0)
            begin
                v0_reg <= in_valid && act_ok;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0 && in_valid)
        begin
            act0_reg <= action;
            ctl0_reg <= ctl0_next;
            a0_reg   <= a;
            b0_reg   <= b;
        end
        if (en1)
        begin
            ctl1_reg <= ctl0_reg;
            opc1_reg <= opc1_next;
            ope1_reg <= ope1_next;
        end
        if (en2)
        begin
            ctl2_reg <= ctl1_reg;
            pc2_reg  <= pc2_next;
            pe2_reg  <= pe2_next;
            for (int j = 0; j < 3; j++)
            begin
                rlo2_reg[j] <= opc1_reg[j][CW-1:0];
                rhi2_reg[j] <= ope1_reg[j][CW-1:0];
            end
        end
        if (en3)
        begin
            ctl3_reg <= ctl2_reg;
            c3_reg   <= c3_next;
            e3_reg   <= e3_next;
            rlo3_reg <= rlo2_reg;
            rhi3_reg <= rhi2_reg;
        end
        if (en4)
        begin
            ctl4_reg <= ctl3_reg;
            lo4_reg  <= lo4_next;
            hi4_reg  <= hi4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_ctl   = ctl4_reg;
    assign out_lo    = lo4_reg;
    assign out_hi    = hi4_reg;

endmodule

FILE: rtl/core/tbb_fold.sv
// ----------------------------------------------------------------------------
// tbb_fold
// Running min/max and result register. Folds candidate boxes, emits the
// bound at the end of a run, passes transformed boxes straight through.
// ----------------------------------------------------------------------------
module tbb_fold (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tbb_pkg::tbb_ctl_t  in_ctl,
    input  tbb_pkg::vec3_t     in_lo,
    input  tbb_pkg::vec3_t     in_hi,
    output logic               out_valid,
    input  logic               out_ready,
    output tbb_pkg::vec3_t     out_lo,
    output tbb_pkg::vec3_t     out_hi
);

    tbb_pkg::vec3_t run_lo_reg, run_lo_next;
    tbb_pkg::vec3_t run_hi_reg, run_hi_next;
    tbb_pkg::vec3_t cand_lo, cand_hi;
    tbb_pkg::vec3_t box_lo_reg, box_lo_next;
    tbb_pkg::vec3_t box_hi_reg, box_hi_next;
    logic           out_valid_reg, out_valid_next;
    logic           take;
    logic           emit;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;
    assign emit     = !in_ctl.fold || in_ctl.last;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cand_lo[i] = ($signed(in_lo[i]) < $signed(run_lo_reg[i])) ? in_lo[i] : run_lo_reg[i];
            cand_hi[i] = ($signed(in_hi[i]) > $signed(run_hi_reg[i])) ? in_hi[i] : run_hi_reg[i];
        end
    end

    always_comb
    begin
        run_lo_next = run_lo_reg;
        run_hi_next = run_hi_reg;
        if (take && in_ctl.fold)
        begin
            if (in_ctl.last)
            begin
                run_lo_next = {3{tbb_pkg::COORD_MAX}};
                run_hi_next = {3{tbb_pkg::COORD_MIN}};
            end
            else
            begin
                run_lo_next = cand_lo;
                run_hi_next = cand_hi;
            end
        end
    end

    always_comb
    begin
        box_lo_next = in_ctl.fold ? cand_lo : in_lo;
        box_hi_next = in_ctl.fold ? cand_hi : in_hi;
        if (take && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_lo_reg    <= {3{tbb_pkg::COORD_MAX}};
            run_hi_reg    <= {3{tbb_pkg::COORD_MIN}};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_lo_reg    <= run_lo_next;
            run_hi_reg    <= run_hi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            box_lo_reg <= box_lo_next;
            box_hi_reg <= box_hi_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_lo    = box_lo_reg;
    assign out_hi    = box_hi_reg;

endmodule

FILE: rtl/core/transformed_bounding_box.sv
// ----------------------------------------------------------------------------
// transformed_bounding_box
// Affine bounding-box engine in Q16.16 with a configurable Q4.12 transform.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_ready is high and passes it through the
// input register, operand forming (2a, a+b, b-a), eighteen 16x33 / 18x33
// multipliers, three-term sums with translation, round and saturate, then
// the running min/max fold into the result register. The fold compares
// against the bound left by the previous item, so runs of vertices stream
// without gaps. in_ready drops only when the result register holds an
// untaken result and every stage behind it is full. Items with action 3
// are accepted and dropped. Configuration writes take effect at once and
// are meant for idle periods.
// ----------------------------------------------------------------------------
module transformed_bounding_box (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tbb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     action,
    input  logic signed [31:0]             a_x,
    input  logic signed [31:0]             a_y,
    input  logic signed [31:0]             a_z,
    input  logic signed [31:0]             b_x,
    input  logic signed [31:0]             b_y,
    input  logic signed [31:0]             b_z,
    input  logic                           is_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [31:0]             lo_x,
    output logic signed [31:0]             lo_y,
    output logic signed [31:0]             lo_z,
    output logic signed [31:0]             hi_x,
    output logic signed [31:0]             hi_y,
    output logic signed [31:0]             hi_z
);

    tbb_pkg::tbb_xf_cfg_t xf_cfg;
    logic                 xf_valid;
    logic                 fold_ready;
    tbb_pkg::tbb_ctl_t    xf_ctl;
    tbb_pkg::vec3_t       xf_lo, xf_hi;
    tbb_pkg::vec3_t       box_lo, box_hi;

    tbb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .xf_cfg    (xf_cfg)
    );

    tbb_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .xf_cfg    (xf_cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .a         ({a_z, a_y, a_x}),
        .b         ({b_z, b_y, b_x}),
        .is_last   (is_last),
        .out_valid (xf_valid),
        .out_ready (fold_ready),
        .out_ctl   (xf_ctl),
        .out_lo    (xf_lo),
        .out_hi    (xf_hi)
    );

    tbb_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xf_valid),
        .in_ready  (fold_ready),
        .in_ctl    (xf_ctl),
        .in_lo     (xf_lo),
        .in_hi     (xf_hi),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_lo    (box_lo),
        .out_hi    (box_hi)
    );

    assign lo_x = box_lo[0];
    assign lo_y = box_lo[1];
    assign lo_z = box_lo[2];
    assign hi_x = box_hi[0];
    assign hi_y = box_hi[1];
    assign hi_z = box_hi[2];

`ifndef NO_ASSERTIONS
    // a transformed box reaching the fold stage is always emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        (xf_valid && fold_ready && !xf_ctl.fold) |=> out_valid)
        else $error("transformed box not emitted");

    // a fold that does not close the run never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (xf_valid && fold_ready && xf_ctl.fold && !xf_ctl.last)
        |=> (out_valid == ($past(out_valid) && !$past(out_ready))))
        else $error("result produced by a non-final fold");

    // with the result register empty nothing may back up to the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");
`endif

endmodule

FILE: sim/transformed_bounding_box_tb.sv
// ----------------------------------------------------------------------------
// transformed_bounding_box_tb
// Self-checking bench for the affine bounding-box engine: an in-bench model of
// the transform, the running min/max fold and the one-shot box transform
// predicts every result box. Directed corner items come first, then random
// runs of vertices, local boxes, box transforms and unused items under several
// transform settings, with bursty input traffic and a stalling result receiver.
// ----------------------------------------------------------------------------
module transformed_bounding_box_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 200;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef logic [tbb_pkg::COEF_W-1:0] coef_t;

    localparam coef_t COEF_ONE  = 16'h1000;
    localparam coef_t COEF_MOST = 16'h7FFF;
    localparam coef_t COEF_LEAST = 16'h8000;
    localparam coef_t COEF_ZERO = 16'h0000;

    localparam tbb_pkg::coord_t Q_ONE = 32'h0001_0000;

    typedef struct packed {
        logic [1:0]     act;
        tbb_pkg::vec3_t a;
        tbb_pkg::vec3_t b;
        logic           last;
    } bb_item_t;

    typedef struct packed {
        tbb_pkg::vec3_t lo;
        tbb_pkg::vec3_t hi;
    } bb_box_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tbb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tbb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [1:0]                     action = '0;
    logic signed [31:0]             a_x = '0;
    logic signed [31:0]             a_y = '0;
    logic signed [31:0]             a_z = '0;
    logic signed [31:0]             b_x = '0;
    logic signed [31:0]             b_y = '0;
    logic signed [31:0]             b_z = '0;
    logic                           is_last = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [31:0]             lo_x;
    logic signed [31:0]             lo_y;
    logic signed [31:0]             lo_z;
    logic signed [31:0]             hi_x;
    logic signed [31:0]             hi_y;
    logic signed [31:0]             hi_z;

    // Transform and running bound as the block should hold them
    tbb_pkg::row_t  xf_row [3];
    tbb_pkg::vec3_t xf_shift;
    tbb_pkg::vec3_t run_lo;
    tbb_pkg::vec3_t run_hi;

    bb_item_t item_backlog [$];
    bb_box_t  bound_exp [$];
    bb_item_t in_hold = '0;
    bit       in_taken = 1'b0;
    int       fail_count = 0;

    int burst_left = 0;
    int gap_left = 0;
    int rx_hold = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;

    string lo_name [3] = '{"lo_x", "lo_y", "lo_z"};
    string hi_name [3] = '{"hi_x", "hi_y", "hi_z"};

    transformed_bounding_box dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .lo_x      (lo_x),
        .lo_y      (lo_y),
        .lo_z      (lo_z),
        .hi_x      (hi_x),
        .hi_y      (hi_y),
        .hi_z      (hi_z)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic longint coef_of(input int r, input int c);
        logic signed [tbb_pkg::COEF_W-1:0] v;
        v = xf_row[r][tbb_pkg::CFG_DATA_W-1-tbb_pkg::COEF_W*c -: tbb_pkg::COEF_W];
        return longint'(v);
    endfunction

    function automatic tbb_pkg::coord_t clamp_q(input longint v);
        if (v > 64'sd2147483647)
        begin
            return tbb_pkg::COORD_MAX;
        end
        if (v < -64'sd2147483648)
        begin
            return tbb_pkg::COORD_MIN;
        end
        return v[31:0];
    endfunction

    task automatic predict_bound(input bb_item_t it);
        longint          acc;
        longint          c2;
        longint          e2;
        longint          m;
        longint          ai;
        longint          bi;
        tbb_pkg::coord_t mn;
        tbb_pkg::coord_t mx;
        bb_box_t         box;
        int              i;
        int              j;
        case (it.act)
            tbb_pkg::ACT_VERTEX, tbb_pkg::ACT_LOCAL_BOX:
            begin
                for (i = 0; i < 3; i++)
                begin
                    if (it.act == tbb_pkg::ACT_VERTEX)
                    begin
                        acc = longint'($signed(xf_shift[i])) * 4096;
                        for (j = 0; j < 3; j++)
                        begin
                            acc += coef_of(i, j) * longint'($signed(it.a[j]));
                        end
                        mn = clamp_q((acc + 2048) >>> 12);
                        mx = mn;
                    end
                    else
                    begin
                        mn = it.a[i];
                        mx = it.b[i];
                    end
                    if ($signed(mn) < $signed(run_lo[i]))
                    begin
                        run_lo[i] = mn;
                    end
                    if ($signed(mx) > $signed(run_hi[i]))
                    begin
                        run_hi[i] = mx;
                    end
                end
                if (it.last)
                begin
                    box.lo = run_lo;
                    box.hi = run_hi;
                    bound_exp = {bound_exp, box};
                    run_lo = {3{tbb_pkg::COORD_MAX}};
                    run_hi = {3{tbb_pkg::COORD_MIN}};
                end
            end
            tbb_pkg::ACT_XFORM_BOX:
            begin
                for (i = 0; i < 3; i++)
                begin
                    c2 = longint'($signed(xf_shift[i])) * 8192;
                    e2 = 0;
                    for (j = 0; j < 3; j++)
                    begin
                        m  = coef_of(i, j);
                        ai = longint'($signed(it.a[j]));
                        bi = longint'($signed(it.b[j]));
                        c2 += m * (ai + bi);
                        e2 += (m < 0 ? -m : m) * (bi - ai);
                    end
                    box.lo[i] = clamp_q((c2 - e2 + 4096) >>> 13);
                    box.hi[i] = clamp_q((c2 + e2 + 4096) >>> 13);
                end
                bound_exp = {bound_exp, box};
            end
            default:
            begin
                // unused action: no result, bound untouched
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            predict_bound(in_hold);
            in_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin : in_drive
        logic nv;
        nv = in_valid;
        if (in_taken)
        begin
            nv = 1'b0;
            in_taken = 1'b0;
        end
        if (rst_n && !nv)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (item_backlog.size() > 0)
            begin
                in_hold = item_backlog.pop_front();
                nv = 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    // new burst; now and then a long one with no gaps at all
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                             : $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                           : $urandom_range(1, 4);
                end
            end
        end
        in_valid <= nv;
        action   <= in_hold.act;
        a_x      <= in_hold.a[0];
        a_y      <= in_hold.a[1];
        a_z      <= in_hold.a[2];
        b_x      <= in_hold.b[0];
        b_y      <= in_hold.b[1];
        b_z      <= in_hold.b[2];
        is_last  <= in_hold.last;
    end

    // ------------------------------------------------------------------------
    // Result receiver: switch between free flow, coin flips and long stalls
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : rx_drive
        logic rdy;
        if (rx_mode_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(64, 256);
        end
        else
        begin
            rx_mode_left--;
        end
        rdy = 1'b1;
        if (rx_hold > 0)
        begin
            rx_hold--;
            rdy = 1'b0;
        end
        else if (rx_mode == 1)
        begin
            rdy = 1'($urandom_range(0, 1));
        end
        else if (rx_mode == 2 && $urandom_range(0, 15) == 0)
        begin
            rx_hold = $urandom_range(5, 30);
            rdy = 1'b0;
        end
        out_ready <= rdy;
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    function automatic void check_coord(input string field, input tbb_pkg::coord_t want,
                                        input tbb_pkg::coord_t got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_mon
        bb_box_t got;
        bb_box_t want;
        int      k;
        if (rst_n && out_valid && out_ready)
        begin
            got.lo = {lo_z, lo_y, lo_x};
            got.hi = {hi_z, hi_y, hi_x};
            if (bound_exp.size() == 0)
            begin
                $error("unexpected result word: lo (%0d %0d %0d) hi (%0d %0d %0d)",
                       lo_x, lo_y, lo_z, hi_x, hi_y, hi_z);
                fail_count++;
            end
            else
            begin
                want = bound_exp.pop_front();
                for (k = 0; k < 3; k++)
                begin
                    check_coord(lo_name[k], want.lo[k], got.lo[k]);
                    check_coord(hi_name[k], want.hi[k], got.hi[k]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no word moves on any channel for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic tbb_pkg::vec3_t v3(input tbb_pkg::coord_t x, input tbb_pkg::coord_t y,
                                          input tbb_pkg::coord_t z);
        return {z, y, x};
    endfunction

    function automatic tbb_pkg::coord_t rand_coord();
        case ($urandom_range(0, 9))
            0: return tbb_pkg::COORD_MAX;
            1: return tbb_pkg::COORD_MIN;
            2, 3, 4, 5: return tbb_pkg::coord_t'($urandom_range(0, 2000 << 16) - (1000 << 16));
            default: return $urandom;
        endcase
    endfunction

    function automatic coef_t rand_coef();
        case ($urandom_range(0, 5))
            0: return COEF_LEAST;
            1: return COEF_MOST;
            2: return $urandom_range(0, 1) ? COEF_ONE : COEF_ZERO;
            3, 4: return coef_t'($urandom_range(0, 16'h4000) - 16'h2000);
            default: return coef_t'($urandom);
        endcase
    endfunction

    function automatic tbb_pkg::row_t rand_row();
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    function automatic bb_item_t rand_item(input logic [1:0] act, input logic last);
        bb_item_t        it;
        tbb_pkg::coord_t t;
        int              i;
        it.act  = act;
        it.last = last;
        for (i = 0; i < 3; i++)
        begin
            it.a[i] = rand_coord();
            it.b[i] = rand_coord();
            // keep most boxes ordered, leave a few inverted
            if ($urandom_range(0, 4) != 0 && $signed(it.a[i]) > $signed(it.b[i]))
            begin
                t = it.a[i];
                it.a[i] = it.b[i];
                it.b[i] = t;
            end
        end
        return it;
    endfunction

    task automatic push_item(input logic [1:0] act, input tbb_pkg::vec3_t a,
                             input tbb_pkg::vec3_t b, input logic last);
        bb_item_t it;
        it.act  = act;
        it.a    = a;
        it.b    = b;
        it.last = last;
        item_backlog = {item_backlog, it};
    endtask

    task automatic write_reg(input logic [tbb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tbb_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            tbb_pkg::CFG_LIN_ROW0: xf_row[0] = data;
            tbb_pkg::CFG_LIN_ROW1: xf_row[1] = data;
            tbb_pkg::CFG_LIN_ROW2: xf_row[2] = data;
            tbb_pkg::CFG_SHIFT_X:  xf_shift[0] = data[tbb_pkg::COORD_W-1:0];
            tbb_pkg::CFG_SHIFT_Y:  xf_shift[1] = data[tbb_pkg::COORD_W-1:0];
            tbb_pkg::CFG_SHIFT_Z:  xf_shift[2] = data[tbb_pkg::COORD_W-1:0];
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_xform(input tbb_pkg::row_t r0, input tbb_pkg::row_t r1,
                              input tbb_pkg::row_t r2, input tbb_pkg::coord_t sx,
                              input tbb_pkg::coord_t sy, input tbb_pkg::coord_t sz);
        write_reg(tbb_pkg::CFG_LIN_ROW0, r0);
        write_reg(tbb_pkg::CFG_LIN_ROW1, r1);
        write_reg(tbb_pkg::CFG_LIN_ROW2, r2);
        write_reg(tbb_pkg::CFG_SHIFT_X, {16'h0000, sx});
        write_reg(tbb_pkg::CFG_SHIFT_Y, {16'h0000, sy});
        write_reg(tbb_pkg::CFG_SHIFT_Z, {16'h0000, sz});
    endtask

    // Hold until every queued word went in and every result came back
    task automatic settle();
        while (item_backlog.size() > 0 || in_valid || bound_exp.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic fill_random(input int count);
        int       n;
        int       k;
        int       len;
        int       mix;
        bit       closed;
        logic [1:0] act;
        n = 0;
        while (n < count)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12:
                begin
                    // accumulation run: vertices, local boxes or a mix
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
                    mix = $urandom_range(0, 2);
                    closed = ($urandom_range(0, 9) != 0);
                    for (k = 0; k < len; k++)
                    begin
                        if (mix == 0)
                        begin
                            act = tbb_pkg::ACT_VERTEX;
                        end
                        else if (mix == 1)
                        begin
                            act = tbb_pkg::ACT_LOCAL_BOX;
                        end
                        else
                        begin
                            act = $urandom_range(0, 1) ? tbb_pkg::ACT_VERTEX
                                                       : tbb_pkg::ACT_LOCAL_BOX;
                        end
                        item_backlog = {item_backlog, rand_item(act, closed && k == len - 1)};
                        n++;
                        // noise inside the run
                        if ($urandom_range(0, 15) == 0)
                        begin
                            item_backlog = {item_backlog,
                                            rand_item(ACT_UNUSED, 1'($urandom_range(0, 1)))};
                        end
                        else if ($urandom_range(0, 15) == 0)
                        begin
                            item_backlog = {item_backlog,
                                            rand_item(tbb_pkg::ACT_XFORM_BOX,
                                                      1'($urandom_range(0, 1)))};
                            n++;
                        end
                    end
                end
                13, 14, 15, 16, 17:
                begin
                    item_backlog = {item_backlog,
                                    rand_item(tbb_pkg::ACT_XFORM_BOX,
                                              1'($urandom_range(0, 1)))};
                    n++;
                end
                default:
                begin
                    item_backlog = {item_backlog,
                                    rand_item(ACT_UNUSED, 1'($urandom_range(0, 1)))};
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        int ph;
        xf_row[0] = tbb_pkg::LIN_ROW0_RST;
        xf_row[1] = tbb_pkg::LIN_ROW1_RST;
        xf_row[2] = tbb_pkg::LIN_ROW2_RST;
        xf_shift  = '0;
        run_lo    = {3{tbb_pkg::COORD_MAX}};
        run_hi    = {3{tbb_pkg::COORD_MIN}};
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset transform. Run closed by its first item.
        push_item(tbb_pkg::ACT_VERTEX, v3(Q_ONE, 2 * Q_ONE, 3 * Q_ONE), '0, 1'b1);
        // Coordinate extremes folded into one bound
        push_item(tbb_pkg::ACT_VERTEX, {3{tbb_pkg::COORD_MAX}}, {3{tbb_pkg::COORD_MIN}}, 1'b0);
        push_item(tbb_pkg::ACT_VERTEX, {3{tbb_pkg::COORD_MIN}}, {3{tbb_pkg::COORD_MAX}}, 1'b0);
        push_item(tbb_pkg::ACT_VERTEX, '0, '0, 1'b1);
        // Box that never moves the bound: extremes come out as they were
        push_item(tbb_pkg::ACT_LOCAL_BOX, {3{tbb_pkg::COORD_MAX}}, {3{tbb_pkg::COORD_MIN}},
                  1'b1);
        // Inverted local box, then a closing vertex
        push_item(tbb_pkg::ACT_LOCAL_BOX, {3{5 * Q_ONE}}, {3{-5 * Q_ONE}}, 1'b0);
        push_item(tbb_pkg::ACT_VERTEX, '0, '0, 1'b1);
        // Unused action with and without last
        push_item(ACT_UNUSED, {3{Q_ONE}}, {3{Q_ONE}}, 1'b1);
        push_item(tbb_pkg::ACT_VERTEX, {3{-Q_ONE}}, '0, 1'b0);
        push_item(ACT_UNUSED, '0, '0, 1'b0);
        // Box transform inside an open run leaves the run alone
        push_item(tbb_pkg::ACT_XFORM_BOX, v3(-Q_ONE, -2 * Q_ONE, -3 * Q_ONE),
                  v3(Q_ONE, 4 * Q_ONE, 9 * Q_ONE), 1'b1);
        push_item(tbb_pkg::ACT_XFORM_BOX, '0, {3{Q_ONE}}, 1'b0);
        push_item(tbb_pkg::ACT_LOCAL_BOX, v3(7, -7, 3), v3(9, 11, 13), 1'b1);
        // Inverted box through the transform, and rounding of tiny negatives
        push_item(tbb_pkg::ACT_XFORM_BOX, {3{3 * Q_ONE}}, {3{-Q_ONE}}, 1'b0);
        push_item(tbb_pkg::ACT_VERTEX, {3{32'hFFFF_FFFF}}, '0, 1'b1);
        settle();

        // Extreme coefficients, including the most negative one, and shifts
        load_xform({COEF_LEAST, COEF_MOST, COEF_LEAST},
                   {COEF_MOST, COEF_LEAST, 16'h0001},
                   {16'hFFFF, COEF_ZERO, COEF_LEAST},
                   tbb_pkg::COORD_MAX, tbb_pkg::COORD_MIN, '0);
        push_item(tbb_pkg::ACT_XFORM_BOX, {3{tbb_pkg::COORD_MIN}}, {3{tbb_pkg::COORD_MAX}},
                  1'b1);
        push_item(tbb_pkg::ACT_XFORM_BOX, {3{tbb_pkg::COORD_MAX}}, {3{tbb_pkg::COORD_MAX}},
                  1'b0);
        push_item(tbb_pkg::ACT_XFORM_BOX, {3{tbb_pkg::COORD_MIN}}, {3{tbb_pkg::COORD_MIN}},
                  1'b1);
        push_item(tbb_pkg::ACT_XFORM_BOX, {3{tbb_pkg::COORD_MAX}}, {3{tbb_pkg::COORD_MIN}},
                  1'b0);
        push_item(tbb_pkg::ACT_VERTEX, {3{tbb_pkg::COORD_MAX}}, '0, 1'b1);
        push_item(tbb_pkg::ACT_VERTEX, {3{tbb_pkg::COORD_MIN}}, '0, 1'b1);
        push_item(tbb_pkg::ACT_VERTEX,
                  v3(tbb_pkg::COORD_MAX, tbb_pkg::COORD_MIN, tbb_pkg::COORD_MAX), '0, 1'b0);
        push_item(tbb_pkg::ACT_LOCAL_BOX, {3{tbb_pkg::COORD_MIN}}, {3{tbb_pkg::COORD_MAX}},
                  1'b1);
        settle();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: load_xform({COEF_ONE, COEF_ZERO, COEF_ZERO},
                              {COEF_ZERO, COEF_ONE, COEF_ZERO},
                              {COEF_ZERO, COEF_ZERO, COEF_ONE}, '0, '0, '0);
                1: load_xform({3{COEF_LEAST}}, {3{COEF_LEAST}}, {3{COEF_LEAST}},
                              tbb_pkg::COORD_MIN, tbb_pkg::COORD_MIN, tbb_pkg::COORD_MIN);
                2: load_xform({3{COEF_MOST}}, {3{COEF_MOST}}, {3{COEF_MOST}},
                              tbb_pkg::COORD_MAX, tbb_pkg::COORD_MAX, tbb_pkg::COORD_MAX);
                3: load_xform('0, '0, '0, rand_coord(), rand_coord(), rand_coord());
                default: load_xform(rand_row(), rand_row(), rand_row(),
                                    rand_coord(), rand_coord(), rand_coord());
            endcase
            fill_random(PHASE_ITEMS);
            settle();
        end

        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
